// ===== hw/rtl/sndl_pkg.sv =====
// Shared types, command codes and the sigmoid table function for the neuron.
// No dependencies.
package sndl_pkg;

	typedef enum logic [1:0] {
		CMD_ACC = 2'd0,
		CMD_FIN = 2'd1,
		CMD_CLR = 2'd2,
		CMD_RD  = 2'd3
	} cmd_t;

	localparam logic KIND_NEW  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam int WEIGHT_W = 16;
	localparam int ACT_W    = 16;
	localparam int DELAY_W  = 6;
	localparam int VALUE_W  = 16;
	localparam int PROD_W   = 33;
	localparam int ACC_W    = 40;

	localparam longint unsigned Q31_ONE = 64'd1 << 31;
	localparam longint unsigned SIG_ONE = 64'd65536;

	// shift-and-subtract quotient, used only while building the table
	function automatic longint unsigned div_u64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			quo = quo << 1;
			if (rem >= den) begin
				rem    = rem - den;
				quo[0] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Entry n of the sigmoid table over [-8,8): exp(-|x|) as a truncated series of
	// exp(-|x|/16) in Q31, squared four times, then 2^47 / (2^31 + e) rounded.
	function automatic logic [15:0] sig_entry(input int unsigned n, input int unsigned entries);
		longint unsigned twice;
		longint unsigned span;
		longint unsigned delta;
		longint unsigned u;
		longint unsigned term;
		longint unsigned e;
		longint unsigned den;
		longint unsigned v;
		longint p;
		bit neg;
		twice = 2 * longint'(n);
		span  = longint'(entries);
		neg   = twice < span;
		delta = neg ? span - twice : twice - span;
		u     = div_u64(delta << 31, span << 1);
		p     = longint'(Q31_ONE);
		term  = Q31_ONE;
		for (int k = 1; k <= 24; k++) begin
			term = div_u64((term * u) >> 31, longint'(k));
			if ((k & 1) == 1) begin
				p = p - longint'(term);
			end else begin
				p = p + longint'(term);
			end
		end
		e = longint'(p);
		for (int k = 0; k < 4; k++) begin
			e = (e * e + (64'd1 << 30)) >> 31;
		end
		den = Q31_ONE + e;
		v   = div_u64((64'd1 << 47) + (den >> 1), den);
		if (neg) begin
			v = SIG_ONE - v;
		end
		if (v > SIG_ONE - 1) begin
			v = SIG_ONE - 1;
		end
		return v[15:0];
	endfunction

endpackage

// ===== hw/rtl/sndl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sndl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/sigmoid_neuron_delay_line.sv =====
// Sigmoid neuron: saturating multiply-accumulate, sigmoid table and a delay line of
// past outputs kept in a circular buffer RAM. Depends on sndl_pkg and sndl_ram.
//
// One input word is taken every cycle, any mix of commands, as long as the output
// side keeps up; a command passes through stage 1 and stage 2 into the output
// register with its result. The accumulator is updated in the stage after the input
// multiply, the table index is formed there too, and the delay line RAM is read
// from that stage and written one stage later, with the newest written value
// forwarded to a read of the same slot. Only a held-off output stalls the input.
// A clear takes effect at once through per-slot valid bits; no clearing
// pass is needed after reset.
module sigmoid_neuron_delay_line
	import sndl_pkg::*;
#(
	parameter int MAX_DELAY = 8,
	parameter int SIGMOID_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // weight[15:0], activation[31:16], read_delay[37:32]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // value[15:0]
	output logic [1:0]  m_tuser    // result_kind[0], status[1]
);

	localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
	localparam int IDX_W = $clog2(SIGMOID_ENTRIES);
	localparam int IPROD_W = 33 + IDX_W;

	// sigmoid table
	logic [VALUE_W-1:0] sig_rom [SIGMOID_ENTRIES];
	for (genvar n = 0; n < SIGMOID_ENTRIES; n++) begin : g_rom
		localparam logic [VALUE_W-1:0] Ent = sig_entry(n, SIGMOID_ENTRIES);
		assign sig_rom[n] = Ent;
	end

	// input decode
	logic signed [WEIGHT_W-1:0] in_weight;
	logic [ACT_W-1:0]           in_act;
	logic signed [PROD_W-1:0]   in_prod;
	assign in_weight = s_tdata[15:0];
	assign in_act    = s_tdata[31:16];
	assign in_prod   = in_weight * $signed({1'b0, in_act});

	logic adv;
	assign s_tready = adv;

	// stage 1
	logic                     vld_s1;
	cmd_t                     cmd_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic [DELAY_W-1:0]       delay_s1;

	// stage 2
	logic               vld_s2;
	cmd_t               cmd_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [AW-1:0]      wa_s2;
	logic               hit_s2;
	logic               ent_vld_s2;
	logic               oor_s2;

	// state
	logic signed [ACC_W-1:0] acc_q;
	logic [AW-1:0]           head_q;
	logic [MAX_DELAY-1:0]    slot_vld_q;
	logic [VALUE_W-1:0]      last_q;
	logic                    ovld_q;
	logic [VALUE_W-1:0]      oval_q;
	logic                    okind_q;
	logic                    ostat_q;

	logic s2_result;
	assign s2_result = vld_s2 && (cmd_s2 == CMD_FIN || cmd_s2 == CMD_RD);
	assign adv = !s2_result || !ovld_q || m_tready;

	// stage 1 combinational: accumulate, table index, read slot
	logic signed [ACC_W:0]   acc_sum;
	logic signed [ACC_W-1:0] acc_sat;
	logic signed [ACC_W:0]   shifted;
	logic                    below;
	logic                    above;
	logic [IPROD_W-1:0]      idx_prod;
	logic [IDX_W-1:0]        idx_s1;
	logic [AW-1:0]           head_nxt;
	logic                    oor_s1;
	logic [DELAY_W:0]        age;
	logic [DELAY_W:0]        diff;
	logic [DELAY_W:0]        slot_w;
	logic [AW-1:0]           rslot;

	always_comb begin
		acc_sum = {acc_q[ACC_W-1], acc_q} + (ACC_W + 1)'(prod_s1);
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_sat = {acc_sum[ACC_W], {(ACC_W - 1){~acc_sum[ACC_W]}}};
		end else begin
			acc_sat = acc_sum[ACC_W-1:0];
		end

		shifted  = {acc_q[ACC_W-1], acc_q} + ((ACC_W + 1)'(1) << 31);
		below    = shifted[ACC_W];
		above    = !below && (|shifted[ACC_W-1:32]);
		idx_prod = IPROD_W'(shifted[31:0]) * IPROD_W'(SIGMOID_ENTRIES);
		if (below) begin
			idx_s1 = '0;
		end else if (above) begin
			idx_s1 = IDX_W'(SIGMOID_ENTRIES - 1);
		end else begin
			idx_s1 = idx_prod[31+IDX_W:32];
		end

		head_nxt = (head_q == AW'(MAX_DELAY - 1)) ? '0 : head_q + AW'(1);

		oor_s1 = (DELAY_W + 1)'(delay_s1) >= (DELAY_W + 1)'(MAX_DELAY);
		age    = oor_s1 ? '0 : (DELAY_W + 1)'(delay_s1);
		diff   = (DELAY_W + 1)'(head_q) - age;
		slot_w = diff[DELAY_W] ? diff + (DELAY_W + 1)'(MAX_DELAY) : diff;
		rslot  = slot_w[AW-1:0];
	end

	// delay line RAM
	logic [VALUE_W-1:0] fin_val;
	logic [VALUE_W-1:0] rdata;
	logic               ram_we;
	assign fin_val = sig_rom[idx_s2];
	assign ram_we  = adv && vld_s2 && cmd_s2 == CMD_FIN;

	sndl_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(MAX_DELAY),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(wa_s2),
		.wdata(fin_val),
		.re(adv),
		.raddr(rslot),
		.rdata(rdata)
	);

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			cmd_s1 <= CMD_ACC;
			cmd_s2 <= CMD_ACC;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			cmd_s1 <= cmd_t'(s_tuser);
			cmd_s2 <= cmd_s1;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1    <= in_prod;
			delay_s1   <= s_tdata[37:32];
			idx_s2     <= idx_s1;
			wa_s2      <= head_nxt;
			hit_s2     <= vld_s2 && cmd_s2 == CMD_FIN && wa_s2 == rslot;
			ent_vld_s2 <= slot_vld_q[rslot];
			oor_s2     <= oor_s1;
		end
		if (ram_we) begin
			last_q <= fin_val;
		end
	end

	// neuron state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			head_q     <= '0;
			slot_vld_q <= '0;
		end else if (adv && vld_s1) begin
			case (cmd_s1)
				CMD_ACC: begin
					acc_q <= acc_sat;
				end
				CMD_FIN: begin
					acc_q              <= '0;
					head_q             <= head_nxt;
					slot_vld_q[head_nxt] <= 1'b1;
				end
				CMD_CLR: begin
					acc_q      <= '0;
					slot_vld_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	logic [VALUE_W-1:0] rd_val;
	assign rd_val = hit_s2 ? last_q : (ent_vld_s2 ? rdata : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (adv && s2_result) begin
			ovld_q <= 1'b1;
		end else if (m_tready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s2_result) begin
			if (cmd_s2 == CMD_FIN) begin
				oval_q  <= fin_val;
				okind_q <= KIND_NEW;
				ostat_q <= 1'b0;
			end else begin
				oval_q  <= rd_val;
				okind_q <= KIND_READ;
				ostat_q <= oor_s2;
			end
		end
	end

	assign m_tvalid = ovld_q;
	assign m_tdata  = oval_q;
	assign m_tuser  = {ostat_q, okind_q};

endmodule
